@@ rtl/core/pl0ct_pkg.sv @@
// ----------------------------------------------------------------------------
// PL/0 tokenizer package
// Shared types and constants: scan modes, token codes, error codes, the
// result record and the keyword table.
// ----------------------------------------------------------------------------
package pl0ct_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_LT,
    MODE_GT,
    MODE_SLASH,
    MODE_COLON,
    MODE_COMMENT,
    MODE_COMMENT_STAR,
    MODE_HOLD
  } scan_mode_t;

  localparam int KIND_W  = 6;
  localparam int VALUE_W = 17;
  localparam int LEN_W   = 4;
  localparam int LOW_W   = 48;
  localparam int HIGH_W  = 40;
  localparam int ERR_W   = 2;

  // Characters reported in a name token, however long names may be.
  localparam int NAME_REPORT = 11;

  localparam logic [KIND_W-1:0] TK_ERROR   = 6'd0;
  localparam logic [KIND_W-1:0] TK_IDENT   = 6'd2;
  localparam logic [KIND_W-1:0] TK_NUMBER  = 6'd3;
  localparam logic [KIND_W-1:0] TK_PLUS    = 6'd4;
  localparam logic [KIND_W-1:0] TK_MINUS   = 6'd5;
  localparam logic [KIND_W-1:0] TK_TIMES   = 6'd6;
  localparam logic [KIND_W-1:0] TK_SLASH   = 6'd7;
  localparam logic [KIND_W-1:0] TK_EQ      = 6'd9;
  localparam logic [KIND_W-1:0] TK_NE      = 6'd10;
  localparam logic [KIND_W-1:0] TK_LT      = 6'd11;
  localparam logic [KIND_W-1:0] TK_LE      = 6'd12;
  localparam logic [KIND_W-1:0] TK_GT      = 6'd13;
  localparam logic [KIND_W-1:0] TK_GE      = 6'd14;
  localparam logic [KIND_W-1:0] TK_LPAREN  = 6'd15;
  localparam logic [KIND_W-1:0] TK_RPAREN  = 6'd16;
  localparam logic [KIND_W-1:0] TK_COMMA   = 6'd17;
  localparam logic [KIND_W-1:0] TK_SEMI    = 6'd18;
  localparam logic [KIND_W-1:0] TK_PERIOD  = 6'd19;
  localparam logic [KIND_W-1:0] TK_BECOMES = 6'd20;

  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NAME_LONG = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NUM_LONG  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_SYMBOL    = 2'd3;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [LEN_W-1:0]   length;
    logic [LOW_W-1:0]   low_chars;
    logic [HIGH_W-1:0]  high_chars;
    logic [ERR_W-1:0]   err;
    logic               last;
  } token_t;

  // Up to two tokens produced by one character.
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } scan_res_t;

  localparam int NUM_KEYWORDS = 15;
  localparam int KW_MAX_LEN   = 9;

  // Keyword text is right aligned: the last character sits in the low byte.
  typedef struct packed {
    logic [8*KW_MAX_LEN-1:0] text;
    logic [3:0]              len;
    logic [KIND_W-1:0]       kind;
  } keyword_t;

  localparam keyword_t KEYWORDS [NUM_KEYWORDS] = '{
    '{"const",     4'd5, 6'd28},
    '{"mod",       4'd3, 6'd1},
    '{"var",       4'd3, 6'd29},
    '{"procedure", 4'd9, 6'd30},
    '{"call",      4'd4, 6'd27},
    '{"begin",     4'd5, 6'd21},
    '{"end",       4'd3, 6'd22},
    '{"if",        4'd2, 6'd23},
    '{"fi",        4'd2, 6'd8},
    '{"then",      4'd4, 6'd24},
    '{"while",     4'd5, 6'd25},
    '{"do",        4'd2, 6'd26},
    '{"read",      4'd4, 6'd32},
    '{"write",     4'd5, 6'd31},
    '{"else",      4'd4, 6'd33}
  };

  // Bits needed to hold any number of the given count of decimal digits.
  function automatic int acc_width(int digits);
    longint v;
    v = 1;
    for (int i = 0; i < digits; i++) begin
      v = v * 10;
    end
    return $clog2(v);
  endfunction

endpackage

@@ rtl/core/pl0ct_in_if.sv @@
// ----------------------------------------------------------------------------
// PL/0 tokenizer character channel
// Valid/ready channel carrying one source character and the end marker.
// ----------------------------------------------------------------------------
interface pl0ct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

@@ rtl/core/pl0ct_out_if.sv @@
// ----------------------------------------------------------------------------
// PL/0 tokenizer token channel
// Valid/ready channel carrying one token record.
// ----------------------------------------------------------------------------
interface pl0ct_out_if import pl0ct_pkg::*;;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  token_kind;
  logic [VALUE_W-1:0] number_value;
  logic [LEN_W-1:0]   name_length;
  logic [LOW_W-1:0]   name_low_chars;
  logic [HIGH_W-1:0]  name_high_chars;
  logic [ERR_W-1:0]   error_code;
  logic               last_of_run;

  modport source (
    output valid, output token_kind, output number_value, output name_length,
    output name_low_chars, output name_high_chars, output error_code,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input number_value, input name_length,
    input name_low_chars, input name_high_chars, input error_code,
    input last_of_run, output ready
  );
endinterface

@@ rtl/core/pl0ct_scan.sv @@
// ----------------------------------------------------------------------------
// PL/0 tokenizer scan logic
// Combinational next-state and token logic for one character, given the
// current scan state and the lexeme collected so far.
// ----------------------------------------------------------------------------
module pl0ct_scan import pl0ct_pkg::*; #(
  parameter int NAME_CHARS    = 11,
  parameter int NUMBER_DIGITS = 5,
  localparam int CW = $clog2(NAME_CHARS + 1),
  localparam int DW = $clog2(NUMBER_DIGITS + 1),
  localparam int AW = acc_width(NUMBER_DIGITS)
) (
  input  scan_mode_t            mode,
  input  logic [7:0]            char_code,
  input  logic                  end_of_input,
  input  logic [8*NAME_CHARS-1:0] lex_flat,
  input  logic [CW-1:0]         lex_count,
  input  logic [AW-1:0]         num_accum,
  input  logic [DW-1:0]         digit_count,
  output scan_mode_t            mode_nxt,
  output logic                  lex_we,
  output logic [CW-1:0]         lex_wr_pos,
  output logic [CW-1:0]         lex_count_nxt,
  output logic [AW-1:0]         num_accum_nxt,
  output logic [DW-1:0]         digit_count_nxt,
  output scan_res_t             res
);

  localparam int LEX_BYTES = (NAME_CHARS > NAME_REPORT) ? NAME_CHARS : NAME_REPORT;
  localparam int LEX_W     = 8 * LEX_BYTES;

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic token_t plain_tok(logic [KIND_W-1:0] kind);
    token_t t;
    t      = '0;
    t.kind = kind;
    return t;
  endfunction

  function automatic token_t err_tok(logic [ERR_W-1:0] code);
    token_t t;
    t      = '0;
    t.kind = TK_ERROR;
    t.err  = code;
    return t;
  endfunction

  // Mode entered when a character starts a fresh token.
  function automatic scan_mode_t start_mode(logic [7:0] c);
    scan_mode_t m;
    m = MODE_IDLE;
    if (is_alpha(c)) begin
      m = MODE_IDENT;
    end else if (is_digit(c)) begin
      m = MODE_NUMBER;
    end else if (c == CH_LT) begin
      m = MODE_LT;
    end else if (c == CH_GT) begin
      m = MODE_GT;
    end else if (c == CH_SLASH) begin
      m = MODE_SLASH;
    end else if (c == CH_COLON) begin
      m = MODE_COLON;
    end else if (!is_space(c) && !(c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_EQ,
               CH_LPAREN, CH_RPAREN, CH_COMMA, CH_SEMI, CH_PERIOD})) begin
      m = MODE_HOLD;
    end
    return m;
  endfunction

  // Token given at once by a starting character, if it gives one.
  function automatic token_t start_tok(logic [7:0] c);
    token_t t;
    case (c)
      CH_PLUS:   t = plain_tok(TK_PLUS);
      CH_MINUS:  t = plain_tok(TK_MINUS);
      CH_STAR:   t = plain_tok(TK_TIMES);
      CH_EQ:     t = plain_tok(TK_EQ);
      CH_LPAREN: t = plain_tok(TK_LPAREN);
      CH_RPAREN: t = plain_tok(TK_RPAREN);
      CH_COMMA:  t = plain_tok(TK_COMMA);
      CH_SEMI:   t = plain_tok(TK_SEMI);
      CH_PERIOD: t = plain_tok(TK_PERIOD);
      default:   t = err_tok(ERR_SYMBOL);
    endcase
    return t;
  endfunction

  logic [LEX_W-1:0]   lex_ext;
  logic [KIND_W-1:0]  kw_kind;
  token_t             ident_tok;
  token_t             number_tok;
  token_t             close_tok;
  logic               close_vld;
  logic               start_en;
  logic               start_vld;
  logic               alnum;
  logic               name_full;
  logic               num_full;
  logic [AW-1:0]      acc_x10;

  assign lex_ext   = LEX_W'(lex_flat);
  assign alnum     = is_alpha(char_code) || is_digit(char_code);
  assign name_full = lex_count >= CW'(NAME_CHARS);
  assign num_full  = digit_count >= DW'(NUMBER_DIGITS);
  // The new value always fits, so wrapping in the shifted terms is harmless.
  assign acc_x10   = AW'(num_accum << 3) + AW'(num_accum << 1) + AW'(char_code[3:0]);

  always_comb begin : keyword_match
    logic hit;
    kw_kind = TK_IDENT;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      hit = (5'(lex_count) == 5'(KEYWORDS[k].len));
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if (j < int'(KEYWORDS[k].len)) begin
          hit = hit && (lex_ext[j*8 +: 8] ==
                8'(KEYWORDS[k].text >> (8 * (int'(KEYWORDS[k].len) - 1 - j))));
        end
      end
      if (hit) begin
        kw_kind = KEYWORDS[k].kind;
      end
    end
  end

  always_comb begin : name_pack
    ident_tok        = '0;
    ident_tok.kind   = kw_kind;
    ident_tok.length = 4'(lex_count);
    for (int i = 0; i < NAME_REPORT; i++) begin
      if (5'(lex_count) > 5'(i)) begin
        if (i < 6) begin
          ident_tok.low_chars[i*8 +: 8] = lex_ext[i*8 +: 8];
        end else begin
          ident_tok.high_chars[(i-6)*8 +: 8] = lex_ext[i*8 +: 8];
        end
      end
    end
    number_tok       = '0;
    number_tok.kind  = TK_NUMBER;
    number_tok.value = VALUE_W'(num_accum);
  end

  always_comb begin : next_state
    mode_nxt = mode;
    if (end_of_input) begin
      mode_nxt = MODE_IDLE;
    end else begin
      case (mode)
        MODE_IDLE:   mode_nxt = start_mode(char_code);
        MODE_IDENT: begin
          if (alnum) begin
            mode_nxt = name_full ? MODE_HOLD : MODE_IDENT;
          end else begin
            mode_nxt = start_mode(char_code);
          end
        end
        MODE_NUMBER: begin
          if (is_digit(char_code)) begin
            mode_nxt = num_full ? MODE_HOLD : MODE_NUMBER;
          end else begin
            mode_nxt = start_mode(char_code);
          end
        end
        MODE_LT: begin
          if (char_code == CH_GT || char_code == CH_EQ) begin
            mode_nxt = MODE_IDLE;
          end else begin
            mode_nxt = start_mode(char_code);
          end
        end
        MODE_GT:     mode_nxt = (char_code == CH_EQ) ? MODE_IDLE : start_mode(char_code);
        MODE_SLASH:  mode_nxt = (char_code == CH_STAR) ? MODE_COMMENT : start_mode(char_code);
        MODE_COLON:  mode_nxt = (char_code == CH_EQ) ? MODE_IDLE : MODE_HOLD;
        MODE_COMMENT: begin
          if (char_code == CH_STAR) begin
            mode_nxt = MODE_COMMENT_STAR;
          end
        end
        MODE_COMMENT_STAR: begin
          if (char_code == CH_SLASH) begin
            mode_nxt = MODE_IDLE;
          end else if (char_code != CH_STAR) begin
            mode_nxt = MODE_COMMENT;
          end
        end
        MODE_HOLD:   mode_nxt = MODE_HOLD;
        default:     mode_nxt = MODE_IDLE;
      endcase
    end
  end

  always_comb begin : outputs
    close_vld       = 1'b0;
    close_tok       = '0;
    start_en        = 1'b0;
    lex_we          = 1'b0;
    lex_wr_pos      = lex_count;
    lex_count_nxt   = lex_count;
    num_accum_nxt   = num_accum;
    digit_count_nxt = digit_count;

    if (end_of_input) begin
      close_vld = 1'b1;
      case (mode)
        MODE_IDENT:  close_tok = ident_tok;
        MODE_NUMBER: close_tok = number_tok;
        MODE_LT:     close_tok = plain_tok(TK_LT);
        MODE_GT:     close_tok = plain_tok(TK_GT);
        MODE_SLASH:  close_tok = plain_tok(TK_SLASH);
        MODE_COLON:  close_tok = err_tok(ERR_SYMBOL);
        default:     close_vld = 1'b0;
      endcase
      lex_count_nxt   = '0;
      num_accum_nxt   = '0;
      digit_count_nxt = '0;
    end else begin
      case (mode)
        MODE_IDLE: start_en = 1'b1;
        MODE_IDENT: begin
          if (alnum) begin
            if (name_full) begin
              close_vld = 1'b1;
              close_tok = err_tok(ERR_NAME_LONG);
            end else begin
              lex_we        = 1'b1;
              lex_count_nxt = CW'(lex_count + 1'b1);
            end
          end else begin
            close_vld = 1'b1;
            close_tok = ident_tok;
            start_en  = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(char_code)) begin
            if (num_full) begin
              close_vld = 1'b1;
              close_tok = err_tok(ERR_NUM_LONG);
            end else begin
              num_accum_nxt   = acc_x10;
              digit_count_nxt = DW'(digit_count + 1'b1);
            end
          end else begin
            close_vld = 1'b1;
            close_tok = number_tok;
            start_en  = 1'b1;
          end
        end
        MODE_LT: begin
          close_vld = 1'b1;
          if (char_code == CH_GT) begin
            close_tok = plain_tok(TK_NE);
          end else if (char_code == CH_EQ) begin
            close_tok = plain_tok(TK_LE);
          end else begin
            close_tok = plain_tok(TK_LT);
            start_en  = 1'b1;
          end
        end
        MODE_GT: begin
          close_vld = 1'b1;
          if (char_code == CH_EQ) begin
            close_tok = plain_tok(TK_GE);
          end else begin
            close_tok = plain_tok(TK_GT);
            start_en  = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (char_code != CH_STAR) begin
            close_vld = 1'b1;
            close_tok = plain_tok(TK_SLASH);
            start_en  = 1'b1;
          end
        end
        MODE_COLON: begin
          close_vld = 1'b1;
          close_tok = (char_code == CH_EQ) ? plain_tok(TK_BECOMES) : err_tok(ERR_SYMBOL);
        end
        default: ;
      endcase

      if (start_en && is_alpha(char_code)) begin
        lex_we        = 1'b1;
        lex_wr_pos    = '0;
        lex_count_nxt = CW'(1);
      end
      if (start_en && is_digit(char_code)) begin
        num_accum_nxt   = AW'(char_code[3:0]);
        digit_count_nxt = DW'(1);
      end
    end

    // A starting character gives a token unless it is white space or opens a longer lexeme.
    start_vld = start_en && (start_mode(char_code) == MODE_IDLE ||
                             start_mode(char_code) == MODE_HOLD) && !is_space(char_code);

    res = '0;
    if (close_vld) begin
      res.first       = close_tok;
      res.second      = start_tok(char_code);
      res.first.last  = !start_vld;
      res.second.last = 1'b1;
      res.count       = start_vld ? 2'd2 : 2'd1;
    end else if (start_vld) begin
      res.first      = start_tok(char_code);
      res.first.last = 1'b1;
      res.count      = 2'd1;
    end
  end

endmodule

@@ rtl/core/pl0_character_tokenizer.sv @@
// ----------------------------------------------------------------------------
// PL/0 character tokenizer
// Scans PL/0 source one character at a time and emits token records.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle while in_chan.ready is high.
// Each character is scanned in the cycle it is accepted, and the zero, one or
// two tokens it completes go into a four-entry token queue, which drives the
// token channel and hands out one token per cycle while the channel is ready.
// A character is accepted whenever at least two queue entries are free, so a
// stream where no character closes two tokens at once runs at one character
// per cycle if the token channel keeps up; a character that closes a pending
// token and also gives one of its own pushes two, which the queue absorbs.
// After an error token, characters are consumed silently to the end marker.
module pl0_character_tokenizer import pl0ct_pkg::*; #(
  parameter int NAME_CHARS    = 11,
  parameter int NUMBER_DIGITS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  pl0ct_in_if.sink    in_chan,
  pl0ct_out_if.source out_chan
);

  localparam int CW     = $clog2(NAME_CHARS + 1);
  localparam int DW     = $clog2(NUMBER_DIGITS + 1);
  localparam int AW     = acc_width(NUMBER_DIGITS);
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);

  scan_mode_t      mode_r, mode_nxt;
  logic [7:0]      lex_r [NAME_CHARS];
  logic [8*NAME_CHARS-1:0] lex_flat;
  logic [CW-1:0]   lex_count_r, lex_count_nxt;
  logic [AW-1:0]   num_accum_r, num_accum_nxt;
  logic [DW-1:0]   digit_count_r, digit_count_nxt;
  logic            lex_we;
  logic [CW-1:0]   lex_wr_pos;
  scan_res_t       res;

  token_t          q_r [QDEPTH];
  logic [QPW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPW:0]    q_cnt_r, q_cnt_nxt;
  logic            accept;
  logic            pop;
  logic [1:0]      push_n;
  token_t          head;

  always_comb begin
    for (int i = 0; i < NAME_CHARS; i++) begin
      lex_flat[i*8 +: 8] = lex_r[i];
    end
  end

  pl0ct_scan #(
    .NAME_CHARS    (NAME_CHARS),
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) u_scan (
    .mode            (mode_r),
    .char_code       (in_chan.char_code),
    .end_of_input    (in_chan.end_of_input),
    .lex_flat        (lex_flat),
    .lex_count       (lex_count_r),
    .num_accum       (num_accum_r),
    .digit_count     (digit_count_r),
    .mode_nxt        (mode_nxt),
    .lex_we          (lex_we),
    .lex_wr_pos      (lex_wr_pos),
    .lex_count_nxt   (lex_count_nxt),
    .num_accum_nxt   (num_accum_nxt),
    .digit_count_nxt (digit_count_nxt),
    .res             (res)
  );

  assign in_chan.ready = q_cnt_r <= (QPW+1)'(QDEPTH - 2);
  assign accept        = in_chan.valid && in_chan.ready;
  assign pop           = out_chan.valid && out_chan.ready;
  assign push_n        = accept ? res.count : 2'd0;

  assign wr_ptr_nxt = QPW'(wr_ptr_r + push_n);
  assign rd_ptr_nxt = QPW'(rd_ptr_r + pop);
  assign q_cnt_nxt  = (QPW+1)'(q_cnt_r + push_n - pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      lex_count_r   <= '0;
      num_accum_r   <= '0;
      digit_count_r <= '0;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      q_cnt_r       <= '0;
    end else begin
      if (accept) begin
        mode_r        <= mode_nxt;
        lex_count_r   <= lex_count_nxt;
        num_accum_r   <= num_accum_nxt;
        digit_count_r <= digit_count_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // Lexeme characters and queue entries hold payload only.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (accept && lex_we && lex_wr_pos == CW'(i)) begin
        lex_r[i] <= in_chan.char_code;
      end
    end
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= res.first;
    end
    if (push_n == 2'd2) begin
      q_r[QPW'(wr_ptr_r + 1'b1)] <= res.second;
    end
  end

  assign head                     = q_r[rd_ptr_r];
  assign out_chan.valid           = q_cnt_r != '0;
  assign out_chan.token_kind      = head.kind;
  assign out_chan.number_value    = head.value;
  assign out_chan.name_length     = head.length;
  assign out_chan.name_low_chars  = head.low_chars;
  assign out_chan.name_high_chars = head.high_chars;
  assign out_chan.error_code      = head.err;
  assign out_chan.last_of_run     = head.last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= (QPW+1)'(QDEPTH))
    else $error("token queue overfilled");

  a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> q_cnt_r == (QPW+1)'($past(q_cnt_r) + $past(push_n) - $past(pop)))
    else $error("token queue count out of step with pushes and pops");

  a_hold_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && mode_r == MODE_HOLD && !in_chan.end_of_input) |-> push_n == 2'd0)
    else $error("token produced while holding after an error");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.end_of_input) |=> mode_r == MODE_IDLE)
    else $error("scanner not idle after end of input");

  a_pair_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n == 2'd2) |-> (!res.first.last && res.second.last))
    else $error("wrong last-of-run marking on a token pair");

endmodule
